// ===== hdl/jpeg_frame_header_checker_macros.svh =====
// Assertion macros shared by the frame header checker modules.
`ifndef JPEG_FRAME_HEADER_CHECKER_MACROS_SVH
`define JPEG_FRAME_HEADER_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JFHC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jfhc same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define JFHC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jfhc next-cycle check failed");

`endif

// ===== hdl/jfhc_pkg.sv =====
// Types, constants and codes for the JPEG frame header checker.
package jfhc_pkg;

  // File length handling
  localparam int MAX_FILE_BYTES = 131072;
  localparam int LEN_W          = 18;

  // Queue between classifier and segment walker
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_TARGET_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT = 1'd1;
  localparam logic [15:0] TARGET_WIDTH_RST  = 16'd480;
  localparam logic [15:0] TARGET_HEIGHT_RST = 16'd240;

  // Marker codes
  localparam logic [7:0] BYTE_FILL   = 8'hff;
  localparam logic [7:0] MARK_SOI    = 8'hd8;
  localparam logic [7:0] MARK_EOI    = 8'hd9;
  localparam logic [7:0] MARK_SOS    = 8'hda;
  localparam logic [7:0] MARK_SOF0   = 8'hc0;
  localparam logic [7:0] MARK_SOF2   = 8'hc2;
  localparam logic [7:0] MARK_RST0   = 8'hd0;
  localparam logic [7:0] MARK_RST7   = 8'hd7;
  localparam logic [7:0] MARK_TEM    = 8'h01;

  // Verdict and cause codes
  localparam logic [1:0] VERDICT_NONE        = 2'd0;
  localparam logic [1:0] VERDICT_BASELINE    = 2'd1;
  localparam logic [1:0] VERDICT_PROGRESSIVE = 2'd2;

  localparam logic [2:0] CAUSE_NO_SOI   = 3'd0;
  localparam logic [2:0] CAUSE_RAN_OUT  = 3'd1;
  localparam logic [2:0] CAUSE_END      = 3'd2;
  localparam logic [2:0] CAUSE_BAD_LEN  = 3'd3;
  localparam logic [2:0] CAUSE_MISMATCH = 3'd4;
  localparam logic [2:0] CAUSE_MATCH    = 3'd5;

  // Segment walker phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SOI1,
    PH_SEEK,
    PH_FILL,
    PH_LENHI,
    PH_LENLO,
    PH_SKIP,
    PH_FRAME
  } phase_t;

  // Input item
  typedef struct packed {
    logic [7:0]       byte_value;
    logic [LEN_W-1:0] file_length;
    logic             first_byte;
  } item_t;

  // Result item
  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] cause;
  } result_t;

  // Classified byte as it sits in the queue
  typedef struct packed {
    logic [7:0]       byte_value;
    logic [LEN_W-1:0] file_length;
    logic             first_byte;
    logic             is_ff;
    logic             is_soi;
    logic             is_end;
    logic             is_standalone;
    logic             is_sof;
    logic             is_baseline;
  } work_t;

  // Queue status toward both sides
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== hdl/jfhc_front.sv =====
// Front end: takes input transfers and classifies each byte for the walker.
module jfhc_front (
  input  logic                   item_valid,
  output logic                   item_stall,
  input  jfhc_pkg::item_t        item,
  input  jfhc_pkg::queue_status_t q_status,
  output logic                   push,
  output jfhc_pkg::work_t        work
);

  logic [7:0] b;

  // Accept whenever the queue has room
  assign item_stall = q_status.full;
  assign push       = item_valid && !q_status.full;
  assign b          = item.byte_value;

  // Byte classification and length clamp
  always_comb begin
    work.byte_value    = b;
    work.first_byte    = item.first_byte;
    work.file_length   = (item.file_length > jfhc_pkg::LEN_W'(jfhc_pkg::MAX_FILE_BYTES))
                         ? jfhc_pkg::LEN_W'(jfhc_pkg::MAX_FILE_BYTES) : item.file_length;
    work.is_ff         = (b == jfhc_pkg::BYTE_FILL);
    work.is_soi        = (b == jfhc_pkg::MARK_SOI);
    work.is_end        = (b == jfhc_pkg::MARK_EOI) || (b == jfhc_pkg::MARK_SOS);
    work.is_standalone = (b == jfhc_pkg::MARK_TEM) ||
                         ((b >= jfhc_pkg::MARK_RST0) && (b <= jfhc_pkg::MARK_RST7));
    work.is_sof        = (b == jfhc_pkg::MARK_SOF0) || (b == jfhc_pkg::MARK_SOF2);
    work.is_baseline   = (b == jfhc_pkg::MARK_SOF0);
  end

endmodule

// ===== hdl/jfhc_queue.sv =====
// Short FIFO of classified bytes between the front end and the walker.
`include "jpeg_frame_header_checker_macros.svh"

module jfhc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  jfhc_pkg::work_t         push_data,
  input  logic                    pop,
  output jfhc_pkg::work_t         head,
  output jfhc_pkg::queue_status_t status
);

  jfhc_pkg::work_t                 mem [jfhc_pkg::QDEPTH];
  logic [jfhc_pkg::PTR_W-1:0]      wr_ptr;
  logic [jfhc_pkg::PTR_W-1:0]      rd_ptr;
  logic [jfhc_pkg::CNT_W-1:0]      count;

  assign status.empty = (count == '0);
  assign status.full  = (count == jfhc_pkg::CNT_W'(jfhc_pkg::QDEPTH));
  assign head         = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `JFHC_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, !status.empty)
  `JFHC_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ===== hdl/jfhc_back.sv =====
// Segment walker: runs the marker scan on queued bytes and holds the verdict.
`include "jpeg_frame_header_checker_macros.svh"

module jfhc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [jfhc_pkg::IDX_W-1:0]    wr_index,
  input  logic [15:0]                   wr_data,
  input  jfhc_pkg::queue_status_t       q_status,
  input  jfhc_pkg::work_t               w,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output jfhc_pkg::result_t             result
);

  localparam int EW = jfhc_pkg::LEN_W + 1;

  // Walker state
  jfhc_pkg::phase_t            phase, phase_next;
  logic [jfhc_pkg::LEN_W-1:0]  pos, pos_next;
  logic                        mark_sof, mark_sof_next;
  logic                        mark_base, mark_base_next;
  logic [7:0]                  len_hi, len_hi_next;
  logic [15:0]                 skip, skip_next;
  logic [15:0]                 fh, fh_next;
  logic [7:0]                  fw_hi, fw_hi_next;
  logic [15:0]                 tgt_w;
  logic [15:0]                 tgt_h;

  // Decision for the current byte
  logic       fin;
  logic [1:0] res_verdict;
  logic [2:0] res_cause;

  // Shared compares
  logic [7:0]  b;
  logic [EW-1:0] n_e;
  logic [EW-1:0] nxt_e;
  logic [15:0] seg_len;
  logic        past_end, room_seg, at_end, len_short, len_bad, frame_go, size_ok;

  assign pop = !q_status.empty && (!result_valid || !result_stall);

  assign b         = w.byte_value;
  assign n_e       = {1'b0, w.file_length};
  assign nxt_e     = {1'b0, pos} + 1'b1;
  assign seg_len   = {len_hi, b};
  assign past_end  = (pos >= w.file_length);
  assign room_seg  = (nxt_e + EW'(8)) < n_e;
  assign at_end    = (nxt_e >= n_e);
  assign len_short = (nxt_e + EW'(2)) > n_e;
  assign len_bad   = (seg_len < 16'd2) ||
                     (({1'b0, pos} - 1'b1 + EW'(seg_len)) > n_e);
  assign frame_go  = mark_sof && (seg_len >= 16'd7);
  assign size_ok   = ({fw_hi, b} == tgt_w) && (fh == tgt_h);

  // Verdict decision
  always_comb begin
    fin         = 1'b0;
    res_verdict = jfhc_pkg::VERDICT_NONE;
    res_cause   = jfhc_pkg::CAUSE_NO_SOI;
    if (w.first_byte) begin
      if ((w.file_length < jfhc_pkg::LEN_W'(4)) || !w.is_ff) begin
        fin       = 1'b1;
        res_cause = jfhc_pkg::CAUSE_NO_SOI;
      end
    end else if (phase != jfhc_pkg::PH_IDLE) begin
      if (past_end) begin
        fin       = 1'b1;
        res_cause = jfhc_pkg::CAUSE_RAN_OUT;
      end else begin
        case (phase)
          jfhc_pkg::PH_SOI1: begin
            if (!w.is_soi) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_NO_SOI;
            end else if (!room_seg) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_RAN_OUT;
            end
          end
          jfhc_pkg::PH_SEEK: begin
            if (w.is_ff ? at_end : !room_seg) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_RAN_OUT;
            end
          end
          jfhc_pkg::PH_FILL: begin
            if (w.is_ff) begin
              if (at_end) begin
                fin       = 1'b1;
                res_cause = jfhc_pkg::CAUSE_RAN_OUT;
              end
            end else if (w.is_end) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_END;
            end else if (w.is_standalone ? !room_seg : len_short) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_RAN_OUT;
            end
          end
          jfhc_pkg::PH_LENLO: begin
            if (len_bad) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_BAD_LEN;
            end else if (!frame_go && (seg_len == 16'd2) && !room_seg) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_RAN_OUT;
            end
          end
          jfhc_pkg::PH_SKIP: begin
            if ((skip == 16'd1) && !room_seg) begin
              fin       = 1'b1;
              res_cause = jfhc_pkg::CAUSE_RAN_OUT;
            end
          end
          jfhc_pkg::PH_FRAME: begin
            if (skip >= 16'd6) begin
              fin = 1'b1;
              if (size_ok) begin
                res_cause   = jfhc_pkg::CAUSE_MATCH;
                res_verdict = mark_base ? jfhc_pkg::VERDICT_BASELINE
                                        : jfhc_pkg::VERDICT_PROGRESSIVE;
              end else begin
                res_cause = jfhc_pkg::CAUSE_MISMATCH;
              end
            end
          end
          default: fin = 1'b0;
        endcase
      end
    end
  end

  // Next walker state
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    mark_sof_next  = mark_sof;
    mark_base_next = mark_base;
    len_hi_next    = len_hi;
    skip_next      = skip;
    fh_next        = fh;
    fw_hi_next     = fw_hi;
    if (w.first_byte) begin
      pos_next       = jfhc_pkg::LEN_W'(1);
      mark_sof_next  = 1'b0;
      mark_base_next = 1'b0;
      len_hi_next    = '0;
      skip_next      = '0;
      fh_next        = '0;
      fw_hi_next     = '0;
      phase_next     = jfhc_pkg::PH_SOI1;
    end else if ((phase != jfhc_pkg::PH_IDLE) && !past_end) begin
      pos_next = nxt_e[jfhc_pkg::LEN_W-1:0];
      case (phase)
        jfhc_pkg::PH_SOI1: phase_next = jfhc_pkg::PH_SEEK;
        jfhc_pkg::PH_SEEK: phase_next = w.is_ff ? jfhc_pkg::PH_FILL : jfhc_pkg::PH_SEEK;
        jfhc_pkg::PH_FILL: begin
          if (!w.is_ff) begin
            mark_sof_next  = w.is_sof;
            mark_base_next = w.is_baseline;
            phase_next     = w.is_standalone ? jfhc_pkg::PH_SEEK : jfhc_pkg::PH_LENHI;
          end
        end
        jfhc_pkg::PH_LENHI: begin
          len_hi_next = b;
          phase_next  = jfhc_pkg::PH_LENLO;
        end
        jfhc_pkg::PH_LENLO: begin
          if (frame_go) begin
            skip_next  = 16'd2;
            phase_next = jfhc_pkg::PH_FRAME;
          end else begin
            skip_next  = seg_len - 16'd2;
            phase_next = (seg_len == 16'd2) ? jfhc_pkg::PH_SEEK : jfhc_pkg::PH_SKIP;
          end
        end
        jfhc_pkg::PH_SKIP: begin
          skip_next = skip - 16'd1;
          if (skip == 16'd1) phase_next = jfhc_pkg::PH_SEEK;
        end
        jfhc_pkg::PH_FRAME: begin
          if (skip == 16'd3)      fh_next    = {b, 8'h00};
          else if (skip == 16'd4) fh_next    = {fh[15:8], b};
          else if (skip == 16'd5) fw_hi_next = b;
          skip_next = skip + 16'd1;
        end
        default: phase_next = jfhc_pkg::PH_IDLE;
      endcase
    end
    // A verdict ends the file
    if (fin) phase_next = jfhc_pkg::PH_IDLE;
  end

  // Walker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= jfhc_pkg::PH_IDLE;
      pos       <= '0;
      mark_sof  <= 1'b0;
      mark_base <= 1'b0;
      len_hi    <= '0;
      skip      <= '0;
      fh        <= '0;
      fw_hi     <= '0;
    end else if (pop) begin
      phase     <= phase_next;
      pos       <= pos_next;
      mark_sof  <= mark_sof_next;
      mark_base <= mark_base_next;
      len_hi    <= len_hi_next;
      skip      <= skip_next;
      fh        <= fh_next;
      fw_hi     <= fw_hi_next;
    end
  end

  // Target size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_w <= jfhc_pkg::TARGET_WIDTH_RST;
      tgt_h <= jfhc_pkg::TARGET_HEIGHT_RST;
    end else if (wr_en) begin
      case (wr_index)
        jfhc_pkg::REG_TARGET_WIDTH:  tgt_w <= wr_data;
        jfhc_pkg::REG_TARGET_HEIGHT: tgt_h <= wr_data;
        default: tgt_w <= tgt_w;
      endcase
    end
  end

  // Result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= pop && fin;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && fin) begin
      result.verdict <= res_verdict;
      result.cause   <= res_cause;
    end
  end

  `JFHC_ASSERT_NEXT(a_fin_idles, clk, rst, pop && fin, result_valid && (phase == jfhc_pkg::PH_IDLE))
  `JFHC_ASSERT_NOW(a_verdict_only_on_match, clk, rst, result_valid && (result.cause != jfhc_pkg::CAUSE_MATCH), result.verdict == jfhc_pkg::VERDICT_NONE)

endmodule

// ===== hdl/jpeg_frame_header_checker.sv =====
// A byte transfer is first written into the queue; its verdict is then registered in the result output register.
// Throughput: one byte per cycle while the queue has room; the walker advances one byte per pop.
// A four-entry queue lets the input keep flowing while a verdict waits on stall.
// Reset (rst, synchronous): queue empties, walker goes idle, no verdict pending,
// target size returns to 480 x 240.
module jpeg_frame_header_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  jfhc_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output jfhc_pkg::result_t           result,
  input  logic                        wr_en,
  input  logic [jfhc_pkg::IDX_W-1:0]  wr_index,
  input  logic [15:0]                 wr_data
);

  jfhc_pkg::queue_status_t q_status;
  jfhc_pkg::work_t         push_data;
  jfhc_pkg::work_t         head;
  logic                    push;
  logic                    pop;

  // Classify and accept
  jfhc_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_status   (q_status),
    .push       (push),
    .work       (push_data)
  );

  // Decoupling queue
  jfhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Segment walker and verdict register
  jfhc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .q_status     (q_status),
    .w            (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== verif/jfhc_verdict_monitor.sv =====
// Verdict monitor for the JPEG frame header checker: byte walker model and result compare.
`timescale 1ns / 100ps

module jfhc_verdict_monitor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        item_stall,
  input  jfhc_pkg::item_t             item,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  jfhc_pkg::result_t           result,
  input  logic                        wr_en,
  input  logic [jfhc_pkg::IDX_W-1:0]  wr_index,
  input  logic [15:0]                 wr_data,
  output int                          errors,
  output int                          pending,
  output int                          verdicts_due,
  output int                          size_hits
);

  // Walker state, kept apart from the block
  jfhc_pkg::phase_t walk;
  int unsigned      pos_next;
  logic [7:0]       mark;
  logic [15:0]      seg_len;
  logic [15:0]      skip_left;
  logic [15:0]      fr_h;
  logic [15:0]      fr_w;
  logic [15:0]      tgt_w;
  logic [15:0]      tgt_h;

  // Verdicts predicted but not yet seen on the result channel
  jfhc_pkg::result_t owed_verdicts[$];

  // Close the file with a verdict
  function automatic bit conclude(input logic [1:0] v, input logic [2:0] c,
                                  output jfhc_pkg::result_t r);
    walk      = jfhc_pkg::PH_IDLE;
    r.verdict = v;
    r.cause   = c;
    return 1'b1;
  endfunction

  // Segment start: at least nine bytes must remain
  function automatic bit next_segment(input int unsigned nxt, input int unsigned n,
                                      output jfhc_pkg::result_t r);
    r = '0;
    if (nxt + 8 < n) begin
      walk = jfhc_pkg::PH_SEEK;
      return 1'b0;
    end
    return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_RAN_OUT, r);
  endfunction

  // Advance the walker by one byte; returns 1 when the byte decides the file
  function automatic bit walk_byte(input jfhc_pkg::item_t it, output jfhc_pkg::result_t r);
    logic [7:0]  bv;
    int unsigned n;
    int unsigned cur;
    int unsigned nxt;
    bv = it.byte_value;
    n  = it.file_length;
    r  = '0;
    if (n > jfhc_pkg::MAX_FILE_BYTES) n = jfhc_pkg::MAX_FILE_BYTES;

    if (it.first_byte) begin
      mark      = '0;
      seg_len   = '0;
      skip_left = '0;
      fr_h      = '0;
      fr_w      = '0;
      pos_next  = 1;
      if (n < 4 || bv != jfhc_pkg::BYTE_FILL)
        return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_NO_SOI, r);
      walk = jfhc_pkg::PH_SOI1;
      return 1'b0;
    end

    // no file running: byte is dropped
    if (walk == jfhc_pkg::PH_IDLE) return 1'b0;

    cur = pos_next;
    if (cur >= n) return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_RAN_OUT, r);
    nxt      = cur + 1;
    pos_next = nxt;

    case (walk)
      jfhc_pkg::PH_SOI1: begin
        if (bv != jfhc_pkg::MARK_SOI)
          return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_NO_SOI, r);
        return next_segment(nxt, n, r);
      end
      jfhc_pkg::PH_SEEK: begin
        if (bv != jfhc_pkg::BYTE_FILL) return next_segment(nxt, n, r);
        walk = jfhc_pkg::PH_FILL;
        if (nxt >= n) return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_RAN_OUT, r);
      end
      jfhc_pkg::PH_FILL: begin
        if (bv == jfhc_pkg::BYTE_FILL) begin
          if (nxt >= n) return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_RAN_OUT, r);
        end else begin
          mark = bv;
          if (bv == jfhc_pkg::MARK_EOI || bv == jfhc_pkg::MARK_SOS)
            return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_END, r);
          if (bv == jfhc_pkg::MARK_TEM ||
              (bv >= jfhc_pkg::MARK_RST0 && bv <= jfhc_pkg::MARK_RST7))
            return next_segment(nxt, n, r);
          // need both length bytes inside the file
          if (nxt + 2 > n) return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_RAN_OUT, r);
          walk = jfhc_pkg::PH_LENHI;
        end
      end
      jfhc_pkg::PH_LENHI: begin
        seg_len = {bv, 8'h00};
        walk    = jfhc_pkg::PH_LENLO;
      end
      jfhc_pkg::PH_LENLO: begin
        seg_len = seg_len | {8'h00, bv};
        if (seg_len < 2 || (cur - 1) + seg_len > n)
          return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_BAD_LEN, r);
        if ((mark == jfhc_pkg::MARK_SOF0 || mark == jfhc_pkg::MARK_SOF2) && seg_len >= 7) begin
          skip_left = 16'd2;
          walk      = jfhc_pkg::PH_FRAME;
        end else begin
          skip_left = seg_len - 16'd2;
          if (skip_left == 0) return next_segment(nxt, n, r);
          walk = jfhc_pkg::PH_SKIP;
        end
      end
      jfhc_pkg::PH_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) return next_segment(nxt, n, r);
      end
      jfhc_pkg::PH_FRAME: begin
        // offset 2 is precision, 3..4 height, 5..6 width
        if (skip_left == 3) fr_h = {bv, 8'h00};
        else if (skip_left == 4) fr_h = fr_h | {8'h00, bv};
        else if (skip_left == 5) fr_w = {bv, 8'h00};
        else if (skip_left >= 6) begin
          fr_w = fr_w | {8'h00, bv};
          if (fr_w == tgt_w && fr_h == tgt_h)
            return conclude((mark == jfhc_pkg::MARK_SOF0) ? jfhc_pkg::VERDICT_BASELINE
                                                          : jfhc_pkg::VERDICT_PROGRESSIVE,
                            jfhc_pkg::CAUSE_MATCH, r);
          return conclude(jfhc_pkg::VERDICT_NONE, jfhc_pkg::CAUSE_MISMATCH, r);
        end
        skip_left = skip_left + 16'd1;
      end
      default: walk = jfhc_pkg::PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // Track register writes, predict on each input transfer, compare each output transfer
  always @(posedge clk) begin : watch
    jfhc_pkg::result_t fresh;
    jfhc_pkg::result_t want;
    if (rst) begin
      walk         = jfhc_pkg::PH_IDLE;
      pos_next     = 0;
      mark         = '0;
      seg_len      = '0;
      skip_left    = '0;
      fr_h         = '0;
      fr_w         = '0;
      tgt_w        = jfhc_pkg::TARGET_WIDTH_RST;
      tgt_h        = jfhc_pkg::TARGET_HEIGHT_RST;
      owed_verdicts.delete();
      errors       = 0;
      verdicts_due = 0;
      size_hits    = 0;
    end else begin
      if (wr_en === 1'b1) begin
        case (wr_index)
          jfhc_pkg::REG_TARGET_WIDTH:  tgt_w = wr_data;
          jfhc_pkg::REG_TARGET_HEIGHT: tgt_h = wr_data;
          default: ;
        endcase
      end

      if (item_valid === 1'b1 && item_stall === 1'b0) begin
        if (walk_byte(item, fresh)) begin
          owed_verdicts.push_back(fresh);
          verdicts_due++;
          if (fresh.cause == jfhc_pkg::CAUSE_MATCH) size_hits++;
        end
      end

      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (owed_verdicts.size() == 0) begin
          errors++;
          $display("%0t: verdict %0d cause %0d arrived with none outstanding",
                   $time, result.verdict, result.cause);
        end else begin
          want = owed_verdicts.pop_front();
          if (result.verdict !== want.verdict) begin
            errors++;
            $display("%0t: verdict expected %0d actual %0d", $time, want.verdict,
                     result.verdict);
          end
          if (result.cause !== want.cause) begin
            errors++;
            $display("%0t: cause expected %0d actual %0d", $time, want.cause,
                     result.cause);
          end
        end
      end
    end
    pending = owed_verdicts.size();
  end

endmodule

// ===== verif/jpeg_frame_header_checker_tb.sv =====
// Testbench top for the JPEG frame header checker: clock, reset, file stimulus, verdict.
`timescale 1ns / 100ps

module jpeg_frame_header_checker_tb;

  logic                        clk;
  logic                        rst;
  logic                        item_valid;
  logic                        item_stall;
  jfhc_pkg::item_t             item;
  logic                        result_valid;
  logic                        result_stall;
  jfhc_pkg::result_t           result;
  logic                        wr_en;
  logic [jfhc_pkg::IDX_W-1:0]  wr_index;
  logic [15:0]                 wr_data;

  int errors;
  int pending;
  int verdicts_due;
  int size_hits;

  // Stimulus bookkeeping
  logic [7:0]  img[$];
  logic [15:0] tw;
  logic [15:0] th;
  bit          calm;
  bit          lazy;
  int          items_sent;
  int          files_sent;

  jpeg_frame_header_checker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  jfhc_verdict_monitor mon (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .errors       (errors),
    .pending      (pending),
    .verdicts_due (verdicts_due),
    .size_hits    (size_hits)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("jpeg_frame_header_checker_tb: errors");
    $finish;
  end

  // Result-side backpressure: random stall bursts, none once calm
  initial begin
    result_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk) result_stall <= 1'b0;
      if (!calm) repeat ($urandom_range(1, 8)) @(posedge clk) result_stall <= 1'b1;
    end
  end

  // One byte transfer, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input int n, input bit first);
    if (!calm && !lazy && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{byte_value: b, file_length: jfhc_pkg::LEN_W'(n), first_byte: first};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send the built file; from byte sw on the length field reads n2
  task automatic ship_file(input int n, input int n2, input int sw);
    for (int i = 0; i < img.size(); i++)
      send_byte(img[i], (i >= sw) ? n2 : n, i == 0);
    files_sent++;
  endtask

  // Hold the sender until every verdict is in and the block has gone quiet
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Both target registers, back to back
  task automatic set_targets(input logic [15:0] w, input logic [15:0] h);
    wr_en    <= 1'b1;
    wr_index <= jfhc_pkg::REG_TARGET_WIDTH;
    wr_data  <= w;
    @(posedge clk);
    wr_index <= jfhc_pkg::REG_TARGET_HEIGHT;
    wr_data  <= h;
    @(posedge clk);
    wr_en    <= 1'b0;
    tw = w;
    th = h;
  endtask

  function automatic void add_segment(input logic [7:0] mk, input int len);
    img.push_back(jfhc_pkg::BYTE_FILL);
    img.push_back(mk);
    img.push_back(8'(len >> 8));
    img.push_back(8'(len));
    repeat (len - 2) img.push_back(8'($urandom));
  endfunction

  function automatic void add_frame(input logic [7:0] mk, input int len,
                                    input logic [15:0] h, input logic [15:0] w);
    img.push_back(jfhc_pkg::BYTE_FILL);
    img.push_back(mk);
    img.push_back(8'(len >> 8));
    img.push_back(8'(len));
    img.push_back(8'd8);
    img.push_back(h[15:8]);
    img.push_back(h[7:0]);
    img.push_back(w[15:8]);
    img.push_back(w[7:0]);
    repeat (len - 7) img.push_back(8'($urandom));
  endfunction

  // Mostly well-formed files with random content; the rest noise or damaged
  task automatic random_file();
    int kind;
    int pick;
    int n;
    int n2;
    int sw;
    logic [15:0] h;
    logic [15:0] w;
    img.delete();
    kind = $urandom_range(0, 99);

    // noise: random bytes, length over the whole field
    if (kind < 8) begin
      repeat ($urandom_range(1, 24)) img.push_back(8'($urandom));
      if ($urandom_range(0, 1)) img[0] = jfhc_pkg::BYTE_FILL;
      n = $urandom_range(0, 1) ? $urandom_range(1, 6)
                               : $urandom_range(1, 2**jfhc_pkg::LEN_W - 1);
      ship_file(n, n, img.size());
      return;
    end

    img.push_back(jfhc_pkg::BYTE_FILL);
    img.push_back(jfhc_pkg::MARK_SOI);
    repeat ($urandom_range(0, 3)) begin
      // stray non-marker byte, then optional fill
      if ($urandom_range(0, 4) == 0) img.push_back(8'($urandom_range(0, 254)));
      repeat ($urandom_range(0, 2)) img.push_back(jfhc_pkg::BYTE_FILL);
      pick = $urandom_range(0, 7);
      case (pick)
        0: begin
          img.push_back(jfhc_pkg::BYTE_FILL);
          img.push_back(jfhc_pkg::MARK_TEM);
        end
        1: begin
          img.push_back(jfhc_pkg::BYTE_FILL);
          img.push_back(8'(jfhc_pkg::MARK_RST0 + $urandom_range(0, 7)));
        end
        2: add_segment(8'h00, $urandom_range(2, 5));          // stuffed zero as marker
        3: add_segment($urandom_range(0, 1) ? jfhc_pkg::MARK_SOF0 : jfhc_pkg::MARK_SOF2,
                       $urandom_range(2, 6));                // frame header too short
        4: begin                                             // arbitrary length field
          img.push_back(jfhc_pkg::BYTE_FILL);
          img.push_back(8'he1);
          img.push_back(8'($urandom));
          img.push_back(8'($urandom));
        end
        default: add_segment(8'(8'he0 + $urandom_range(0, 15)), $urandom_range(2, 12));
      endcase
    end

    // how the file ends
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      img.push_back(jfhc_pkg::BYTE_FILL);
      img.push_back(jfhc_pkg::MARK_EOI);
    end else if (pick == 1) begin
      img.push_back(jfhc_pkg::BYTE_FILL);
      img.push_back(jfhc_pkg::MARK_SOS);
    end else begin
      h = th;
      w = tw;
      case ($urandom_range(0, 3))
        2: h = th ^ 16'($urandom_range(1, 65535));
        3: w = tw ^ 16'($urandom_range(1, 65535));
        default: ;
      endcase
      add_frame($urandom_range(0, 1) ? jfhc_pkg::MARK_SOF0 : jfhc_pkg::MARK_SOF2,
                $urandom_range(7, 17), h, w);
    end
    n  = img.size() + $urandom_range(0, 12);
    n2 = n;
    sw = img.size();

    // damage
    if (kind < 30) begin
      case ($urandom_range(0, 3))
        0: img[$urandom_range(1, img.size() - 1)] = 8'($urandom);
        1: n = $urandom_range(1, img.size());
        2: begin
          n2 = $urandom_range(1, img.size() + 4);
          sw = $urandom_range(1, img.size() - 1);
        end
        default: repeat ($urandom_range(1, img.size() - 2)) img.pop_back();  // cut short
      endcase
    end
    // trailing bytes past the verdict
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) img.push_back(8'($urandom));
    ship_file(n, n2, sw);
  endtask

  // Main sequence
  initial begin
    int start_items;
    int start_verdicts;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    wr_en      <= 1'b0;
    wr_index   <= jfhc_pkg::REG_TARGET_WIDTH;
    wr_data    <= '0;
    calm       = 1'b0;
    lazy       = 1'b0;
    items_sent = 0;
    files_sent = 0;
    tw         = jfhc_pkg::TARGET_WIDTH_RST;
    th         = jfhc_pkg::TARGET_HEIGHT_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte with no file, short length, missing SOI, fill and standalone markers
    // ahead of a matching baseline header with an oversized length, SOS, too few bytes
    send_byte(8'haa, 100, 1'b0);
    img = '{jfhc_pkg::BYTE_FILL};
    ship_file(3, 3, 1);
    img = '{jfhc_pkg::BYTE_FILL, 8'h00};
    ship_file(40, 40, 2);
    img = '{jfhc_pkg::BYTE_FILL, jfhc_pkg::MARK_SOI, jfhc_pkg::BYTE_FILL, jfhc_pkg::BYTE_FILL,
            jfhc_pkg::MARK_RST0, jfhc_pkg::BYTE_FILL, jfhc_pkg::MARK_TEM};
    add_frame(jfhc_pkg::MARK_SOF0, 7, th, tw);
    ship_file(2**jfhc_pkg::LEN_W - 1, 2**jfhc_pkg::LEN_W - 1, img.size());
    img = '{jfhc_pkg::BYTE_FILL, jfhc_pkg::MARK_SOI, jfhc_pkg::BYTE_FILL, jfhc_pkg::MARK_SOS};
    ship_file(jfhc_pkg::MAX_FILE_BYTES, jfhc_pkg::MAX_FILE_BYTES, 4);
    img = '{jfhc_pkg::BYTE_FILL, jfhc_pkg::MARK_SOI};
    ship_file(10, 10, 2);

    // Random phases, each under its own target size; the last one runs without idle bursts or result stalls
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: set_targets(16'd1, 16'hffff);
          2: set_targets(16'hffff, 16'd1);
          3: set_targets(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
          default: set_targets(16'($urandom_range(1, 1023)), 16'($urandom_range(1, 1023)));
        endcase
      end
      calm           = (ph == 4);
      start_items    = items_sent;
      start_verdicts = verdicts_due;
      while (items_sent - start_items < 80 || verdicts_due - start_verdicts < 10) begin
        lazy = ($urandom_range(0, 2) == 0);
        random_file();
        if ($urandom_range(0, 19) == 0) settle();
      end
    end
    settle();

    $display("covered %0d byte transfers in %0d files, %0d verdicts, %0d size matches",
             items_sent, files_sent, verdicts_due, size_hits);
    $display("target sizes: reset, 1 x 65535, 65535 x 1 and two random settings");
    if (errors == 0) begin
      $display("jpeg_frame_header_checker_tb: clean");
    end else begin
      $display("jpeg_frame_header_checker_tb: errors");
    end
    $finish;
  end

endmodule
